// File: hw/rtl/dcmv_pkg.sv
// ----------------------------------------------------------------------------
// dcmv_pkg
// shared types, constants and command codes for the motor/vehicle plant step
// ----------------------------------------------------------------------------
package dcmv_pkg;

  localparam int unsigned QW = 32;   // q16.16 word
  localparam int unsigned RW = 31;   // register width
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [QW-1:0] EPSILON   = 32'sd655;
  localparam logic signed [QW-1:0] FORCE_CAP = 32'sd327680;

  localparam logic [RW-1:0] DRIVE_GAIN_RST = 31'd65536;
  localparam logic [RW-1:0] GEAR_RST       = 31'd3276800;
  localparam logic [RW-1:0] RADIUS_RST     = 31'd6554;
  localparam logic [RW-1:0] ROLL_RST       = 31'd131072;
  localparam logic [RW-1:0] STAT_RST       = 31'd196608;
  localparam logic [RW-1:0] MASS_RST       = 31'd32768;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STAT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASS       = 3'd5;

  // datapath micro-operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // latch inputs, energy = sat(drive*gain)
    OP_DIV_TARM,  // start t_arm = energy / max(omega, eps)
    OP_MUL_TWHL,  // t_wheel = t_arm * gear
    OP_DIV_FWHL,  // start f_wheel = t_wheel / radius
    OP_DIV_VG,    // cap force, start omega / gear
    OP_MUL_VVEH,  // v_veh = q * radius
    OP_FORCE,     // friction, start accel = f / mass
    OP_MUL_DV,    // v_veh += accel * dt, floor 0
    OP_DIV_VR,    // start v_veh / radius
    OP_MUL_OMEGA  // omega = q * gear, store
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_sts_t;

  function automatic logic signed [QW-1:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[QW-1:0];
  endfunction

endpackage

// File: hw/rtl/dcmv_if.sv
// ----------------------------------------------------------------------------
// dcmv_in_if / dcmv_out_if
// valid/ready channels for plant step items and results
// ----------------------------------------------------------------------------
interface dcmv_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive_value;
  logic [15:0]        time_step;
  modport source (output valid, output drive_value, output time_step, input ready);
  modport sink   (input valid, input drive_value, input time_step, output ready);
endinterface

interface dcmv_out_if;
  logic               valid;
  logic               ready;
  logic [30:0]        armature_speed;
  logic signed [31:0] net_force;
  modport source (output valid, output armature_speed, output net_force, input ready);
  modport sink   (input valid, input armature_speed, input net_force, output ready);
endinterface

// File: hw/rtl/dcmv_div.sv
// ----------------------------------------------------------------------------
// dcmv_div
// restoring divider, one quotient bit per cycle, signed dividend, positive
// divisor, q16.16 quotient truncated toward zero and saturated to 32 bits
// ----------------------------------------------------------------------------
module dcmv_div import dcmv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [QW-1:0] dividend,
  input  logic [RW-1:0]        divisor,
  output logic                 busy,
  output logic signed [QW-1:0] quot
);
  localparam int unsigned NB = 48;  // |a|*2^16 fits 48 bits

  logic [NB-1:0]  num_r, num_nxt;
  logic [RW:0]    rem_r, rem_nxt;
  logic [RW-1:0]  den_r, den_nxt;
  logic           neg_r, neg_nxt;
  logic [5:0]     cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic [QW:0]    mag;
  logic [RW+1:0]  trial;
  logic [NB-1:0]  qmag;
  logic signed [65:0] qs;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    mag      = '0;
    trial    = {rem_r, num_r[NB-1]} - {2'b0, den_r};
    if (start) begin
      mag      = dividend[QW-1] ? (33'd0 - {dividend[QW-1], dividend})
                                : {1'b0, dividend};
      num_nxt  = {mag[NB-17:0], 16'd0};
      rem_nxt  = '0;
      den_nxt  = (divisor == '0) ? RW'(1) : divisor;
      neg_nxt  = dividend[QW-1];
      cnt_nxt  = 6'(NB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[RW+1]) begin
        rem_nxt = trial[RW:0];
        num_nxt = {num_r[NB-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[RW-1:0], num_r[NB-1]};
        num_nxt = {num_r[NB-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 6'd1;
      busy_nxt = (cnt_r != 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign qmag = num_r;
  assign qs   = neg_r ? -$signed({18'd0, qmag}) : $signed({18'd0, qmag});
  assign quot = sat32(qs);
  assign busy = busy_r;
endmodule

// File: hw/rtl/dcmv_datapath.sv
// ----------------------------------------------------------------------------
// dcmv_datapath
// configuration registers, speed state, shared multiplier and divider
// ----------------------------------------------------------------------------
module dcmv_datapath import dcmv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [RW-1:0]        cfg_wdata,
  input  dp_cmd_t              cmd,
  input  logic signed [15:0]   drive_value,
  input  logic [15:0]          time_step,
  output dp_sts_t              sts,
  output logic [RW-1:0]        armature_speed,
  output logic signed [QW-1:0] net_force
);
  logic [RW-1:0] gain_r, gear_r, radius_r, roll_r, stat_r, mass_r;
  logic signed [QW-1:0] omega_r, acc_r, vveh_r, force_r;
  logic [15:0]   dt_r;

  logic [RW-1:0] gear_e, radius_e, mass_e;
  logic                 div_start;
  logic signed [QW-1:0] div_a;
  logic [RW-1:0]        div_b;
  logic                 div_busy;
  logic signed [QW-1:0] quot;
  logic signed [QW-1:0] mul_a;
  logic signed [QW:0]   mul_b;
  logic signed [65:0]   prod;
  logic signed [65:0]   prod_q;
  logic signed [QW-1:0] mulq;
  logic signed [QW:0]   fdiff;
  logic signed [QW:0]   vsum;
  logic signed [QW-1:0] fcap, fv, vs;

  assign gear_e   = (gear_r   == '0) ? RW'(1) : gear_r;
  assign radius_e = (radius_r == '0) ? RW'(1) : radius_r;
  assign mass_e   = (mass_r   == '0) ? RW'(1) : mass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= DRIVE_GAIN_RST;
      gear_r   <= GEAR_RST;
      radius_r <= RADIUS_RST;
      roll_r   <= ROLL_RST;
      stat_r   <= STAT_RST;
      mass_r   <= MASS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DRIVE_GAIN: gain_r   <= cfg_wdata;
        REG_GEAR:       gear_r   <= cfg_wdata;
        REG_RADIUS:     radius_r <= cfg_wdata;
        REG_ROLL:       roll_r   <= cfg_wdata;
        REG_STAT:       stat_r   <= cfg_wdata;
        REG_MASS:       mass_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // one multiplier, operands selected by op
  // the quotient holds on the divider output until the next start, so a
  // multiply right after a division takes it directly
  always_comb begin
    mul_a = acc_r;
    mul_b = {2'b0, gear_e};
    case (cmd.op)
      OP_LOAD:      begin mul_a = QW'(drive_value); mul_b = {2'b0, gain_r}; end
      OP_MUL_TWHL:  begin mul_a = quot; mul_b = {2'b0, gear_e}; end
      OP_MUL_VVEH:  begin mul_a = quot; mul_b = {2'b0, radius_e}; end
      OP_MUL_DV:    begin mul_a = quot; mul_b = {17'd0, dt_r}; end
      OP_MUL_OMEGA: begin mul_a = quot; mul_b = {2'b0, gear_e}; end
      default: ;
    endcase
  end
  assign prod   = 66'(mul_a) * 66'(mul_b);
  assign prod_q = prod / 66'sd65536;
  assign mulq   = sat32(prod_q);

  // division operand selection
  always_comb begin
    div_start = 1'b0;
    div_a     = acc_r;
    div_b     = gear_e;
    case (cmd.op)
      OP_DIV_TARM: begin
        div_start = 1'b1;
        div_a     = acc_r;
        div_b     = (omega_r > EPSILON) ? omega_r[RW-1:0] : EPSILON[RW-1:0];
      end
      OP_DIV_FWHL: begin div_start = 1'b1; div_a = acc_r; div_b = radius_e; end
      OP_DIV_VG:   begin div_start = 1'b1; div_a = omega_r; div_b = gear_e; end
      OP_FORCE:    begin div_start = 1'b1; div_a = fv; div_b = mass_e; end
      OP_DIV_VR:   begin div_start = 1'b1; div_a = vs; div_b = radius_e; end
      default: ;
    endcase
  end

  dcmv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quot     (quot)
  );

  // force cap on the wheel force quotient, then friction
  assign fcap  = (quot > FORCE_CAP) ? FORCE_CAP : quot;
  always_comb begin
    if (vveh_r < EPSILON) begin
      fdiff = {force_r[QW-1], force_r} - {2'b0, stat_r};
      fv    = sat32(66'(fdiff));
      if (fv[QW-1]) fv = '0;
    end else begin
      fdiff = {force_r[QW-1], force_r} - {2'b0, roll_r};
      fv    = sat32(66'(fdiff));
    end
  end
  assign vsum = {vveh_r[QW-1], vveh_r} + {mulq[QW-1], mulq};
  assign vs   = vveh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omega_r <= '0;
    end else if (cmd.op == OP_MUL_OMEGA) begin
      omega_r <= mulq[QW-1] ? '0 : mulq;
    end
    case (cmd.op)
      OP_LOAD: begin
        dt_r  <= time_step;
        acc_r <= sat32(prod);
      end
      OP_MUL_TWHL:  acc_r <= mulq;
      OP_DIV_VG:    force_r <= fcap;
      OP_MUL_VVEH:  vveh_r <= mulq;
      OP_FORCE:     force_r <= fv;
      OP_MUL_DV: begin
        vveh_r <= (sat32(66'(vsum)) < 0) ? '0 : sat32(66'(vsum));
      end
      default: ;
    endcase
  end

  assign sts.div_busy  = div_busy | div_start;
  assign armature_speed = omega_r[RW-1:0];
  assign net_force      = force_r;
endmodule

// File: hw/rtl/dcmv_ctrl.sv
// ----------------------------------------------------------------------------
// dcmv_ctrl
// step sequencer issuing datapath operations
// ----------------------------------------------------------------------------
module dcmv_ctrl import dcmv_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_fire,
  input  logic    out_fire,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    in_ready,
  output logic    out_valid
);
  typedef enum logic [3:0] {
    S_IDLE, S_TARM, S_W1, S_TWHL, S_FWHL, S_W2, S_VG, S_W3, S_VVEH,
    S_FORCE, S_W4, S_DV, S_VR, S_W5, S_OMEGA, S_OUT
  } state_t;

  state_t state_r;

  always_comb begin
    cmd.op = OP_NONE;
    case (state_r)
      S_IDLE:  if (in_fire) cmd.op = OP_LOAD;
      S_TARM:  cmd.op = OP_DIV_TARM;
      S_TWHL:  cmd.op = OP_MUL_TWHL;
      S_FWHL:  cmd.op = OP_DIV_FWHL;
      S_VG:    cmd.op = OP_DIV_VG;
      S_VVEH:  cmd.op = OP_MUL_VVEH;
      S_FORCE: cmd.op = OP_FORCE;
      S_DV:    cmd.op = OP_MUL_DV;
      S_VR:    cmd.op = OP_DIV_VR;
      S_OMEGA: cmd.op = OP_MUL_OMEGA;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE:  if (in_fire) state_r <= S_TARM;
        S_TARM:  state_r <= S_W1;
        S_W1:    if (!sts.div_busy) state_r <= S_TWHL;
        S_TWHL:  state_r <= S_FWHL;
        S_FWHL:  state_r <= S_W2;
        S_W2:    if (!sts.div_busy) state_r <= S_VG;
        S_VG:    state_r <= S_W3;
        S_W3:    if (!sts.div_busy) state_r <= S_VVEH;
        S_VVEH:  state_r <= S_FORCE;
        S_FORCE: state_r <= S_W4;
        S_W4:    if (!sts.div_busy) state_r <= S_DV;
        S_DV:    state_r <= S_VR;
        S_VR:    state_r <= S_W5;
        S_W5:    if (!sts.div_busy) state_r <= S_OMEGA;
        S_OMEGA: state_r <= S_OUT;
        S_OUT:   if (out_fire) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
endmodule

// File: hw/rtl/dc_motor_vehicle_sim_step_core.sv
// a new item is accepted only in idle, after the previous result has been taken;
// each step runs five divisions (start, 48 bits, done) on the single shared
// bit-serial divider
// reset: synchronous active-low rst_n; configuration registers take their defaults and
// the stored armature speed clears to zero
// ----------------------------------------------------------------------------
// dc_motor_vehicle_sim_step_core
// dc motor and vehicle plant emulator, one step per item
// ----------------------------------------------------------------------------
module dc_motor_vehicle_sim_step_core import dcmv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [RW-1:0]        cfg_wdata,
  dcmv_in_if.sink              in_ch,
  dcmv_out_if.source           out_ch
);
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_fire, out_fire;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_fire = out_ch.valid & out_ch.ready;

  // sequencer
  dcmv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .out_fire  (out_fire),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  // arithmetic and state
  dcmv_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .drive_value    (in_ch.drive_value),
    .time_step      (in_ch.time_step),
    .sts            (sts),
    .armature_speed (out_ch.armature_speed),
    .net_force      (out_ch.net_force)
  );
endmodule
